// ===== hw/rtl/krsm_pkg.sv =====
// keyed record set merge: shared constants, record layout and codes
// no dependencies

`timescale 1ns / 1ps

package krsm_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// key sits in the lowest bits, stock in the highest
	typedef struct packed {
		logic [15:0] stock;
		logic [23:0] price;
		logic [7:0]  kind;
		logic [31:0] key;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef enum logic {
		MODE_STORE = 1'b0,
		MODE_PROBE = 1'b1
	} mode_t;

	typedef enum logic {
		OP_INTERSECT = 1'b0,
		OP_UNION     = 1'b1
	} set_op_t;

	typedef enum logic {
		STATUS_NORMAL = 1'b0,
		STATUS_FULL   = 1'b1
	} status_t;

endpackage

// ===== hw/rtl/keyed_record_set_merge.sv =====
// keyed record set merge: top level with record table, probe scan and output register
// depends on krsm_pkg and krsm_ram

`timescale 1ns / 1ps

// Items with tuser = 0 are first-list records: they are appended to a table of
// TABLE_DEPTH entries and, in union mode or when the table is full, leave at
// once (status 1 means the table was full and the record was not kept). Items
// with tuser = 1 probe the table by key: the table ram gives one entry per cycle
// (the scan stops at the first matching entry, the lowest address wins).
// In intersect mode a hit emits the stored record; in union mode a miss emits the
// probe record. One item is worked on at a time. set_operation is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, which the
// block itself does not enforce, and it takes effect with the next item; the table
// keeps its contents. No clearing pass follows reset.

module keyed_record_set_merge
	import krsm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,   // set_operation
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [REC_W-1:0] s_tdata,     // key, kind, price, stock
	input  logic [0:0]       s_tuser,     // mode
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [REC_W-1:0] m_tdata,     // out_key, out_kind, out_price, out_stock
	output logic [0:0]       m_tuser      // status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT
	} state_t;

	state_t     state_q;
	set_op_t    set_op_q;
	logic [CNT_W-1:0] entry_cnt_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic       pend_s1;
	logic       m_tvalid_q;
	rec_t       m_rec_q;
	status_t    m_status_q;
	rec_t       probe_q;
	rec_t       res_q;

	rec_t       rec_in;
	rec_t       rd_rec;
	logic [REC_W-1:0] ram_rdata;
	logic       in_xfer;
	logic       is_store;
	logic       full;
	logic       store_emit;
	logic       ram_we;
	logic       issue;
	logic       hit;
	logic       miss;
	logic       out_free;

	always_comb begin
		rec_in     = rec_t'(s_tdata);
		rd_rec     = rec_t'(ram_rdata);
		out_free   = !m_tvalid_q || m_tready;
		s_tready   = (state_q == S_IDLE) && out_free;
		in_xfer    = s_tvalid && s_tready;
		is_store   = (mode_t'(s_tuser[0]) == MODE_STORE);
		full       = (entry_cnt_q == CNT_W'(TABLE_DEPTH));
		ram_we     = in_xfer && is_store && !full;
		store_emit = in_xfer && is_store && (full || set_op_q == OP_UNION);
		issue      = (state_q == S_SCAN) && (scan_idx_q != entry_cnt_q);
		hit        = (state_q == S_SCAN) && pend_s1 && (rd_rec.key == probe_q.key);
		miss       = (state_q == S_SCAN) && !hit && (scan_idx_q == entry_cnt_q);
	end

	krsm_ram #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(REC_W)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (entry_cnt_q[ADDR_W-1:0]),
		.wdata (s_tdata),
		.re    (issue),
		.raddr (scan_idx_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			set_op_q    <= OP_INTERSECT;
			entry_cnt_q <= '0;
			scan_idx_q  <= '0;
			pend_s1     <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				set_op_q <= set_op_t'(cfg_wdata);
			end
			m_tvalid_q <= store_emit || (state_q == S_EMIT && out_free)
				|| (m_tvalid_q && !m_tready);
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (is_store) begin
							if (!full) begin
								entry_cnt_q <= entry_cnt_q + CNT_W'(1);
							end
						end else begin
							scan_idx_q <= '0;
							pend_s1    <= 1'b0;
							state_q    <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					pend_s1 <= issue && !hit;
					if (issue) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end
					if (hit) begin
						state_q <= (set_op_q == OP_INTERSECT) ? S_EMIT : S_IDLE;
					end else if (miss) begin
						state_q <= (set_op_q == OP_UNION) ? S_EMIT : S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (store_emit) begin
			m_rec_q    <= rec_in;
			m_status_q <= full ? STATUS_FULL : STATUS_NORMAL;
		end
		if (in_xfer && !is_store) begin
			probe_q <= rec_in;
		end
		if (hit) begin
			res_q <= rd_rec;
		end else if (miss) begin
			res_q <= probe_q;
		end
		if (state_q == S_EMIT && out_free) begin
			m_rec_q    <= res_q;
			m_status_q <= STATUS_NORMAL;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_rec_q;
	assign m_tuser  = m_status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q != $past(entry_cnt_q) |-> entry_cnt_q == $past(entry_cnt_q) + CNT_W'(1))
		else $error("entry count moved by more than one");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> scan_idx_q <= entry_cnt_q)
		else $error("scan index past stored entries");

	a_pend_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> state_q == S_SCAN)
		else $error("table read outstanding outside scan");

endmodule

// ===== hw/rtl/krsm_ram.sv =====
// keyed record set merge: simple dual-port ram, one write and one registered read port
// no dependencies

`timescale 1ns / 1ps

module krsm_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 80,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== tb/testbench.sv =====
// testbench for keyed_record_set_merge: directed table walk, then random record streams
// checked against an in-bench model of the record table; depends on krsm_pkg and the rtl

`timescale 1ns / 1ps

module testbench;
	import krsm_pkg::*;

	localparam int IDLE_LIMIT    = 5000;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 165;
	localparam int KEY_POOL      = 40;

	typedef struct {
		rec_t    rec;
		status_t status;
	} merge_out_t;

	typedef struct {
		set_op_t    op;
		mode_t      mode;
		rec_t       rec;
		bit         typed;
		bit         typed_emits;
		merge_out_t typed_out;
	} stim_row_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic             cfg_wdata = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [REC_W-1:0] s_tdata   = '0;   // key, kind, price, stock
	logic [0:0]       s_tuser   = '0;   // mode
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [REC_W-1:0] m_tdata;          // out_key, out_kind, out_price, out_stock
	logic [0:0]       m_tuser;          // status

	// model of the record table
	rec_t        stored_recs [TABLE_DEPTH];
	int unsigned stored_count = 0;
	set_op_t     op_now       = OP_INTERSECT;

	merge_out_t  expected_q [$];
	stim_row_t   directed_rows [$];
	logic [31:0] key_pool [KEY_POOL];
	int          fail_count = 0;
	int          sink_hold  = 0;
	bit          src_calm   = 1'b0;
	bit          sink_calm  = 1'b0;

	keyed_record_set_merge DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic rec_t mk_rec(input logic [31:0] key, input logic [7:0] kind,
			input logic [23:0] price, input logic [15:0] stock);
		rec_t r;
		r.key   = key;
		r.kind  = kind;
		r.price = price;
		r.stock = stock;
		return r;
	endfunction

	function automatic void add_row(input set_op_t op, input mode_t m, input rec_t r,
			input bit typed, input bit emits, input rec_t exp_rec);
		stim_row_t row;
		row.op                 = op;
		row.mode               = m;
		row.rec                = r;
		row.typed              = typed;
		row.typed_emits        = emits;
		row.typed_out.rec      = exp_rec;
		row.typed_out.status   = STATUS_NORMAL;
		directed_rows.push_back(row);
	endfunction

	// stores append or overflow, probes scan for the lowest matching entry
	function automatic bit predict_merge(input mode_t m, input rec_t r, output merge_out_t res);
		res.rec    = r;
		res.status = STATUS_NORMAL;
		if (m == MODE_STORE) begin
			if (stored_count >= TABLE_DEPTH) begin
				res.status = STATUS_FULL;
				return 1'b1;
			end
			stored_recs[stored_count] = r;
			stored_count++;
			return op_now == OP_UNION;
		end
		for (int i = 0; i < stored_count; i++) begin
			if (stored_recs[i].key == r.key) begin
				res.rec = stored_recs[i];
				return op_now == OP_INTERSECT;
			end
		end
		return op_now == OP_UNION;
	endfunction

	function automatic int pick_gap(input bit calm);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic send_record(input mode_t m, input rec_t r, input bit typed,
			input bit typed_emits, input merge_out_t typed_out);
		merge_out_t res;
		bit         emits;
		int         gap;
		s_tvalid <= 1'b1;
		s_tdata  <= r;
		s_tuser  <= m;
		do @(posedge clk); while (s_tready !== 1'b1);
		emits = predict_merge(m, r, res);
		if (typed) begin
			emits = typed_emits;
			res   = typed_out;
		end
		if (emits)
			expected_q.push_back(res);
		gap = pick_gap(src_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain, let a silent probe scan finish, then write the operation
	task automatic change_op(input set_op_t op);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= op;
		@(posedge clk);
		cfg_we <= 1'b0;
		op_now = op;
	endtask

	initial begin : stimulus
		merge_out_t none;
		rec_t       r;
		mode_t      m;
		none.rec    = '0;
		none.status = STATUS_NORMAL;

		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int k = 2; k < KEY_POOL; k++)
			key_pool[k] = $urandom;

		// op, mode, record, typed, emits, expected record
		add_row(OP_INTERSECT, MODE_PROBE, mk_rec(32'h0, 8'h0, 24'h0, 16'h0), 1, 0, '0);
		add_row(OP_INTERSECT, MODE_STORE, mk_rec(32'h0, 8'h0, 24'h0, 16'h0), 1, 0, '0);
		add_row(OP_INTERSECT, MODE_STORE,
			mk_rec(32'hFFFF_FFFF, 8'hFF, 24'hFF_FFFF, 16'hFFFF), 1, 0, '0);
		add_row(OP_INTERSECT, MODE_STORE, mk_rec(32'h1234_5678, 8'h01, 24'd100, 16'd7), 0, 0, '0);
		add_row(OP_INTERSECT, MODE_STORE, mk_rec(32'h1234_5678, 8'h02, 24'd200, 16'd8), 0, 0, '0);
		add_row(OP_INTERSECT, MODE_PROBE,
			mk_rec(32'h0, 8'hFF, 24'hFF_FFFF, 16'hFFFF), 1, 1, mk_rec(32'h0, 8'h0, 24'h0, 16'h0));
		add_row(OP_INTERSECT, MODE_PROBE, mk_rec(32'hFFFF_FFFF, 8'h0, 24'h0, 16'h0), 1, 1,
			mk_rec(32'hFFFF_FFFF, 8'hFF, 24'hFF_FFFF, 16'hFFFF));
		add_row(OP_INTERSECT, MODE_PROBE, mk_rec(32'h1234_5678, 8'h33, 24'd1, 16'd1), 0, 0, '0);
		add_row(OP_INTERSECT, MODE_PROBE, mk_rec(32'hDEAD_BEEF, 8'h44, 24'd2, 16'd2), 0, 0, '0);
		add_row(OP_UNION, MODE_STORE, mk_rec(32'hA5A5_A5A5, 8'h5A, 24'h5A_5A5A, 16'h5A5A), 0, 0, '0);
		add_row(OP_UNION, MODE_PROBE, mk_rec(32'hA5A5_A5A5, 8'h11, 24'd3, 16'd3), 0, 0, '0);
		add_row(OP_UNION, MODE_PROBE, mk_rec(32'h0BAD_F00D, 8'h22, 24'd4, 16'd4), 0, 0, '0);
		add_row(OP_UNION, MODE_PROBE, mk_rec(32'h0, 8'h66, 24'd5, 16'd5), 0, 0, '0);
		add_row(OP_UNION, MODE_PROBE, mk_rec(32'hFFFF_FFFF, 8'h77, 24'd6, 16'd6), 0, 0, '0);
		add_row(OP_UNION, MODE_STORE, mk_rec(32'h0, 8'h88, 24'd9, 16'd9), 0, 0, '0);
		add_row(OP_INTERSECT, MODE_PROBE, mk_rec(32'hA5A5_A5A5, 8'h0, 24'd0, 16'd0), 0, 0, '0);
		add_row(OP_INTERSECT, MODE_PROBE, mk_rec(32'h0BAD_F00D, 8'h0, 24'd0, 16'd0), 0, 0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].op != op_now)
				change_op(directed_rows[i].op);
			send_record(directed_rows[i].mode, directed_rows[i].rec, directed_rows[i].typed,
				directed_rows[i].typed_emits, directed_rows[i].typed_out);
		end

		// table fills partway through, later stores overflow
		for (int p = 0; p < PHASES; p++) begin
			change_op((p % 2 == 0) ? OP_UNION : OP_INTERSECT);
			src_calm  = (p == 2);
			sink_calm = (p == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				m = mode_t'($urandom_range(0, 1));
				if ($urandom_range(0, 99) < 85)
					r.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
				else
					r.key = $urandom;
				r.kind  = 8'($urandom);
				r.price = 24'($urandom);
				r.stock = 16'($urandom);
				send_record(m, r, 1'b0, 1'b0, none);
			end
		end
		s_tvalid <= 1'b0;

		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin : out_check
		merge_out_t want;
		rec_t       got;
		if (m_tvalid === 1'b1 && m_tready) begin
			got = m_tdata;
			if (expected_q.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected output transfer: key %h kind %h price %h stock %h status %b",
						got.key, got.kind, got.price, got.stock, m_tuser[0]);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				if (got.key !== want.rec.key || got.kind !== want.rec.kind
						|| got.price !== want.rec.price || got.stock !== want.rec.stock
						|| m_tuser[0] !== want.status) begin
					if (fail_count < 10) begin
						$display("output mismatch: expected key %h kind %h price %h stock %h status %b",
							want.rec.key, want.rec.kind, want.rec.price, want.rec.stock,
							want.status);
						$display("                 got      key %h kind %h price %h stock %h status %b",
							got.key, got.kind, got.price, got.stock, m_tuser[0]);
					end
					fail_count++;
				end
			end
		end
		// receiver stalls
		if (sink_hold > 0)
			sink_hold--;
		else
			sink_hold = pick_gap(sink_calm);
		m_tready <= (sink_hold == 0);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/krsm_pkg.sv
hw/rtl/krsm_ram.sv
hw/rtl/keyed_record_set_merge.sv
tb/testbench.sv
